// ----- rtl/acmac_pkg.sv -----
// ----------------------------------------------------------------------------
// AES-CMAC package
// Shared types, constants and AES helper functions for the CMAC tag block.
// ----------------------------------------------------------------------------
package acmac_pkg;

   localparam logic [7:0] CMAC_RB  = 8'h87;
   localparam logic [7:0] CMAC_PAD = 8'h80;
   localparam logic [4:0] FULL_BYTES = 5'd16;

   localparam logic [0:0] REG_KEY_HIGH = 1'b0;
   localparam logic [0:0] REG_KEY_LOW  = 1'b1;

   typedef struct packed {
      logic [127:0] data;
      logic [4:0]   byte_count;
      logic         last_block;
   } req_type;

   function automatic logic [7:0] sbox(input logic [7:0] x);
      logic [7:0] tab [256];
      tab = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
      return tab[x];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] rcon(input logic [3:0] r);
      logic [7:0] v;
      case (r)
         4'd1: v = 8'h01;
         4'd2: v = 8'h02;
         4'd3: v = 8'h04;
         4'd4: v = 8'h08;
         4'd5: v = 8'h10;
         4'd6: v = 8'h20;
         4'd7: v = 8'h40;
         4'd8: v = 8'h80;
         4'd9: v = 8'h1b;
         4'd10: v = 8'h36;
         default: v = 8'h00;
      endcase
      return v;
   endfunction

   // Byte i of a 128-bit word sits at bits [127-8i -: 8].
   function automatic logic [127:0] next_round_key(input logic [127:0] k,
                                                   input logic [3:0] r);
      logic [31:0] w0, w1, w2, w3, t;
      w0 = k[127:96];
      w1 = k[95:64];
      w2 = k[63:32];
      w3 = k[31:0];
      t = {sbox(w3[23:16]) ^ rcon(r), sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
      w0 = w0 ^ t;
      w1 = w1 ^ w0;
      w2 = w2 ^ w1;
      w3 = w3 ^ w2;
      return {w0, w1, w2, w3};
   endfunction

   function automatic logic [127:0] aes_round(input logic [127:0] s,
                                              input logic [127:0] rk,
                                              input logic mix);
      logic [7:0] b [16];
      logic [7:0] t [16];
      logic [7:0] a0, a1, a2, a3, al;
      logic [127:0] o;
      for (int i = 0; i < 16; i++) begin
         b[i] = s[127-8*i -: 8];
      end
      for (int c = 0; c < 4; c++) begin
         for (int i = 0; i < 4; i++) begin
            t[c*4+i] = sbox(b[((c+i)%4)*4+i]);
         end
      end
      if (mix) begin
         for (int c = 0; c < 4; c++) begin
            a0 = t[c*4];
            a1 = t[c*4+1];
            a2 = t[c*4+2];
            a3 = t[c*4+3];
            al = a0 ^ a1 ^ a2 ^ a3;
            t[c*4]   = a0 ^ al ^ xtime(a0 ^ a1);
            t[c*4+1] = a1 ^ al ^ xtime(a1 ^ a2);
            t[c*4+2] = a2 ^ al ^ xtime(a2 ^ a3);
            t[c*4+3] = a3 ^ al ^ xtime(a3 ^ a0);
         end
      end
      for (int i = 0; i < 16; i++) begin
         o[127-8*i -: 8] = t[i];
      end
      return o ^ rk;
   endfunction

   function automatic logic [127:0] dbl(input logic [127:0] x);
      return {x[126:0], 1'b0} ^ {120'd0, (x[127] ? CMAC_RB : 8'h00)};
   endfunction

endpackage

// ----- rtl/acmac_keys.sv -----
// ----------------------------------------------------------------------------
// AES-CMAC key schedule and subkeys
// Holds the key, expands it one round key per register stage, and derives
// K1 and K2 from AES of zero using the final cipher stage of that chain.
// ----------------------------------------------------------------------------
module acmac_keys (
   input  logic                clock,
   input  logic                reset,
   input  logic                key_we,
   input  logic [127:0]        key_in,
   output logic [127:0]        key_out,
   output logic [127:0]        round_keys [11],
   output logic                ready,
   output logic [127:0]        subkey_one,
   output logic [127:0]        subkey_two
);

   logic [127:0] key_ff;
   logic [127:0] rk_ff [11];
   logic [127:0] st_ff [11];
   logic [11:0]  vld_ff;
   logic [127:0] k1_ff, k2_ff;
   logic         ready_ff;

   assign key_out = key_ff;
   assign round_keys = rk_ff;
   assign ready = ready_ff;
   assign subkey_one = k1_ff;
   assign subkey_two = k2_ff;

   // Register chain: stage 0 loads the key, each later stage adds one
   // round key and one cipher round on the all-zero block.
   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff   <= '0;
         vld_ff   <= '0;
         ready_ff <= 1'b0;
      end else begin
         if (key_we) begin
            key_ff <= key_in;
         end
         vld_ff <= key_we ? '0 : {vld_ff[10:0], 1'b1};
         if (key_we) begin
            ready_ff <= 1'b0;
         end else if (vld_ff[11]) begin
            ready_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rk_ff[0] <= key_ff;
      st_ff[0] <= key_ff;
      for (int r = 1; r < 11; r++) begin
         rk_ff[r] <= acmac_pkg::next_round_key(rk_ff[r-1], 4'(r));
         st_ff[r] <= acmac_pkg::aes_round(st_ff[r-1],
                        acmac_pkg::next_round_key(rk_ff[r-1], 4'(r)), r < 10);
      end
      if (vld_ff[11] && !ready_ff) begin
         k1_ff <= acmac_pkg::dbl(st_ff[10]);
         k2_ff <= acmac_pkg::dbl(acmac_pkg::dbl(st_ff[10]));
      end
   end

endmodule

// ----- rtl/acmac_core.sv -----
// ----------------------------------------------------------------------------
// AES-CMAC block path
// Applies padding and subkey to a registered last block, chains every block
// through an unrolled ten-round AES and updates the chain value.
// ----------------------------------------------------------------------------
module acmac_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  acmac_pkg::req_type  in_req,
   input  logic [127:0]        round_keys [11],
   input  logic [127:0]        subkey_one,
   input  logic [127:0]        subkey_two,
   output logic [127:0]        tag,
   output logic                tag_valid
);

   logic [127:0] chain_ff, chain_in;
   logic [127:0] msg, x, s;
   logic [4:0]   n;

   always_comb begin
      n = (in_req.byte_count > acmac_pkg::FULL_BYTES) ? acmac_pkg::FULL_BYTES
                                                      : in_req.byte_count;
      msg = in_req.data;
      if (in_req.last_block) begin
         if (n == acmac_pkg::FULL_BYTES) begin
            msg = msg ^ subkey_one;
         end else begin
            for (int j = 0; j < 16; j++) begin
               if (5'(j) == n) begin
                  msg[127-8*j -: 8] = acmac_pkg::CMAC_PAD;
               end else if (5'(j) > n) begin
                  msg[127-8*j -: 8] = 8'h00;
               end
            end
            msg = msg ^ subkey_two;
         end
      end
      x = msg ^ chain_ff ^ round_keys[0];
      s = x;
      for (int r = 1; r < 11; r++) begin
         s = acmac_pkg::aes_round(s, round_keys[r], r < 10);
      end
      chain_in = chain_ff;
      if (in_valid) begin
         chain_in = in_req.last_block ? '0 : s;
      end
   end

   assign tag       = s;
   assign tag_valid = in_valid && in_req.last_block;

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= '0;
      end else begin
         chain_ff <= chain_in;
      end
   end

endmodule

// ----- rtl/aes_cmac_tag.sv -----
// ----------------------------------------------------------------------------
// AES-128 CMAC tag generator
// Streams 16-byte blocks and returns one 128-bit tag per message.
// ----------------------------------------------------------------------------
// One block is accepted per cycle once the subkeys are ready, unless a last
// block waits in the input register. After reset or a key write, the key
// schedule pipeline derives K1 and K2, during which req_tready is low. A block
// is registered in the input register and then passes the unrolled AES rounds;
// for a last block the tag is registered and offered on rsp. The output
// register is backed by one skid entry, so two tags can wait on a stalled rsp
// side; a further last block then waits in the input register and req_tready
// stays low until the skid entry drains.
module aes_cmac_tag (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [135:0] req_tdata,   // block_high, block_low, byte_count
   input  logic         req_tlast,   // last_block
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,   // tag_high, tag_low
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [63:0]  csr_pwdata,
   output logic [63:0]  csr_prdata,
   output logic         csr_pready
);

   logic [127:0] key_cur, key_in;
   logic [127:0] rks [11];
   logic [127:0] k1, k2, tag;
   logic         keys_ready, key_we, tag_valid;
   logic         in_ff_valid_ff, in_take;
   acmac_pkg::req_type in_ff;
   logic [127:0] out_ff, skid_ff;
   logic         out_valid_ff, skid_valid_ff;
   logic         cfg_wr;

   assign csr_pready = 1'b1;
   assign cfg_wr = csr_psel && csr_penable && csr_pwrite;
   assign key_we = cfg_wr && (csr_paddr[2:0] == 3'd0);
   always_comb begin
      key_in = key_cur;
      if (csr_paddr[3] == acmac_pkg::REG_KEY_HIGH) begin
         key_in[127:64] = csr_pwdata;
      end else begin
         key_in[63:0] = csr_pwdata;
      end
      csr_prdata = (csr_paddr[3] == acmac_pkg::REG_KEY_HIGH) ? key_cur[127:64]
                                                             : key_cur[63:0];
   end

   acmac_keys u_keys (
      .clock(clock), .reset(reset), .key_we(key_we), .key_in(key_in),
      .key_out(key_cur), .round_keys(rks), .ready(keys_ready),
      .subkey_one(k1), .subkey_two(k2)
   );

   assign in_take = in_ff_valid_ff && (!in_ff.last_block || !skid_valid_ff);
   assign req_tready = keys_ready && !key_we && (!in_ff_valid_ff || in_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_ff_valid_ff <= 1'b0;
      end else begin
         in_ff_valid_ff <= (req_tvalid && req_tready) || (in_ff_valid_ff && !in_take);
      end
      if (req_tvalid && req_tready) begin
         in_ff.data       <= {req_tdata[63:0], req_tdata[127:64]};
         in_ff.byte_count <= req_tdata[132:128];
         in_ff.last_block <= req_tlast;
      end
   end

   acmac_core u_core (
      .clock(clock), .reset(reset), .in_valid(in_take), .in_req(in_ff),
      .round_keys(rks), .subkey_one(k1), .subkey_two(k2),
      .tag(tag), .tag_valid(tag_valid)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (!out_valid_ff || rsp_tready) begin
            out_valid_ff  <= skid_valid_ff || tag_valid;
            skid_valid_ff <= skid_valid_ff && tag_valid;
         end else if (tag_valid) begin
            skid_valid_ff <= 1'b1;
         end
      end
      if (!out_valid_ff || rsp_tready) begin
         out_ff <= skid_valid_ff ? skid_ff : tag;
         if (skid_valid_ff) begin
            skid_ff <= tag;
         end
      end else if (tag_valid) begin
         skid_ff <= tag;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_ff[63:0], out_ff[127:64]};

   a_no_accept_unready: assert property (@(posedge clock) disable iff (reset)
      !keys_ready |-> !req_tready) else $error("block taken before subkeys");
   a_key_clears_ready: assert property (@(posedge clock) disable iff (reset)
      key_we |=> !keys_ready) else $error("key write kept subkeys ready");
   a_skid_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      tag_valid |-> !skid_valid_ff) else $error("tag pushed into a full skid entry");

endmodule
